/* hw/rtl/ffa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int OFF_W        = 12;
    localparam int SIZE_W       = 13;
    localparam int NEED_W       = SIZE_W + 1;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_ZERO    = 3'd1;
    localparam status_t ST_NOSPACE = 3'd2;
    localparam status_t ST_NULL    = 3'd3;
    localparam status_t ST_DOUBLE  = 3'd4;
    localparam status_t ST_UNKNOWN = 3'd5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] payload;
        logic              is_free;
    } seg_entry_t;

    localparam int ENTRY_W = $bits(seg_entry_t);

endpackage
`default_nettype wire

/* hw/rtl/first_fit_arena_allocator_top.sv */
// first-fit arena allocator over a 4096-byte arena with 8-byte segment headers
// input channel: in_valid/in_ready carrying cmd, alloc_size and free_offset
// output channel: out_valid/out_ready carrying payload_offset and status
// one result item per input item, in order
// the segment table (up to 64 entries) sits in a single-port ram with a
// registered read; every step is one ram access, so each table entry takes
// a read state and a check or write state in the search and in each shift
// allocate: scans the table to find the segment, shifts the later entries
// up to open a slot, then writes the free remainder and the new segment
// free: scans the table to find the segment, plus a shift-down of the
// later entries of the table for each merge
// rejected requests (zero size, null pointer, full table) skip the table scan
// after reset the block writes the initial free segment in its init state,
// with in_ready low
// a finished result waits in an output register; the next item is taken
// while it waits, but a new result is held back until the receiver takes
// the old one
`timescale 1ns / 1ps
`default_nettype none
module first_fit_arena_allocator_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        cmd,
    input  wire logic [ffa_pkg::SIZE_W-1:0]  alloc_size,
    input  wire logic [ffa_pkg::OFF_W-1:0]   free_offset,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [ffa_pkg::OFF_W-1:0]   payload_offset,
    output ffa_pkg::status_t                 status
);

    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_A_W1, S_A_W2,
        S_NX_RD, S_NX_CHK, S_DR_RD, S_DR_WR, S_PV_RD, S_PV_CHK, S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic              cmd_reg, cmd_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    seg_entry_t        cur_reg, cur_next;
    logic              ret_prev_reg, ret_prev_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    status_t           res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]  out_off_reg, out_off_next;
    status_t           out_st_reg, out_st_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    seg_entry_t        ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    seg_entry_t        rd;
    logic [SIZE_W:0]   hdr_start;

    ffa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd        = seg_entry_t'(ram_rdata);
    assign hdr_start = {2'b00, rd.start} + (SIZE_W+1)'(HEADER_BYTES);

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign payload_offset = out_off_reg;
    assign status         = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pick_next      = pick_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        need_next      = need_reg;
        off_next       = off_reg;
        cur_next       = cur_reg;
        ret_prev_next  = ret_prev_reg;
        res_off_next   = res_off_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_off_next   = out_off_reg;
        out_st_next    = out_st_reg;
        ram_we         = 1'b0;
        ram_addr       = idx_reg[IDX_W-1:0];
        ram_wdata      = cur_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we            = 1'b1;
                ram_addr          = '0;
                ram_wdata.start   = '0;
                ram_wdata.payload = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
                ram_wdata.is_free = 1'b1;
                count_next        = CNT_W'(1);
                state_next        = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    size_next    = alloc_size;
                    need_next    = {1'b0, alloc_size} + NEED_W'(HEADER_BYTES);
                    off_next     = free_offset;
                    idx_next     = '0;
                    res_off_next = '0;
                    state_next   = S_SCAN_RD;
                    if (cmd == CMD_ALLOC)
                    begin
                        if (alloc_size == '0)
                        begin
                            res_st_next = ST_ZERO;
                            state_next  = S_RESP;
                        end
                        else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                        begin
                            res_st_next = ST_NOSPACE;
                            state_next  = S_RESP;
                        end
                    end
                    else if (free_offset == '0)
                    begin
                        res_st_next = ST_NULL;
                        state_next  = S_RESP;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    res_st_next = (cmd_reg == CMD_ALLOC) ? ST_NOSPACE : ST_UNKNOWN;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                pick_next  = idx_reg[IDX_W-1:0];
                cur_next   = rd;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_SCAN_RD;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (rd.is_free && ({1'b0, rd.payload} >= need_reg))
                    begin
                        idx_next   = count_reg;
                        state_next = S_SH_RD;
                    end
                end
                else if (hdr_start == {2'b00, off_reg})
                begin
                    if (rd.is_free)
                    begin
                        res_st_next = ST_DOUBLE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        cur_next.is_free = 1'b1;
                        state_next       = S_NX_RD;
                    end
                end
            end
            S_SH_RD:
            begin
                ram_addr = IDX_W'(idx_reg - CNT_W'(1));
                if (idx_reg > ({1'b0, pick_reg} + CNT_W'(1)))
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_A_W1;
                end
            end
            S_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = rd;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = S_SH_RD;
            end
            S_A_W1:
            begin
                ram_we            = 1'b1;
                ram_addr          = pick_reg + IDX_W'(1);
                ram_wdata.start   = cur_reg.start + OFF_W'(need_reg);
                ram_wdata.payload = cur_reg.payload - SIZE_W'(need_reg);
                ram_wdata.is_free = 1'b1;
                state_next        = S_A_W2;
            end
            S_A_W2:
            begin
                ram_we            = 1'b1;
                ram_addr          = pick_reg;
                ram_wdata.start   = cur_reg.start;
                ram_wdata.payload = size_reg;
                ram_wdata.is_free = 1'b0;
                count_next        = count_reg + CNT_W'(1);
                res_off_next      = cur_reg.start + OFF_W'(HEADER_BYTES);
                res_st_next       = ST_OK;
                state_next        = S_RESP;
            end
            S_NX_RD:
            begin
                ram_addr = pick_reg + IDX_W'(1);
                if (({1'b0, pick_reg} + CNT_W'(1)) < count_reg)
                begin
                    state_next = S_NX_CHK;
                end
                else
                begin
                    state_next = S_PV_RD;
                end
            end
            S_NX_CHK:
            begin
                state_next = S_PV_RD;
                if (rd.is_free)
                begin
                    cur_next.payload = cur_reg.payload + rd.payload
                                     + SIZE_W'(HEADER_BYTES);
                    idx_next         = {1'b0, pick_reg} + CNT_W'(1);
                    ret_prev_next    = 1'b1;
                    state_next       = S_DR_RD;
                end
            end
            S_DR_RD:
            begin
                ram_addr = IDX_W'(idx_reg + CNT_W'(1));
                if ((idx_reg + CNT_W'(1)) < count_reg)
                begin
                    state_next = S_DR_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ret_prev_reg ? S_PV_RD : S_RESP;
                end
            end
            S_DR_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = rd;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_DR_RD;
            end
            S_PV_RD:
            begin
                ram_addr    = pick_reg - IDX_W'(1);
                res_st_next = ST_OK;
                if (pick_reg != '0)
                begin
                    state_next = S_PV_CHK;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_addr   = pick_reg;
                    state_next = S_RESP;
                end
            end
            S_PV_CHK:
            begin
                ram_we = 1'b1;
                if (rd.is_free)
                begin
                    ram_addr          = pick_reg - IDX_W'(1);
                    ram_wdata         = rd;
                    ram_wdata.payload = rd.payload + cur_reg.payload
                                      + SIZE_W'(HEADER_BYTES);
                    idx_next          = {1'b0, pick_reg};
                    ret_prev_next     = 1'b0;
                    state_next        = S_DR_RD;
                end
                else
                begin
                    ram_addr   = pick_reg;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pick_reg     <= pick_next;
        cmd_reg      <= cmd_next;
        size_reg     <= size_next;
        need_reg     <= need_next;
        off_reg      <= off_next;
        cur_reg      <= cur_next;
        ret_prev_reg <= ret_prev_next;
        res_off_reg  <= res_off_next;
        res_st_reg   <= res_st_next;
        out_off_reg  <= out_off_next;
        out_st_reg   <= out_st_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INIT) |-> (count_reg != '0 && count_reg <= CNT_W'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> !ram_we)
        else $error("table written outside a request");

    a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_W2) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("allocate did not add a segment");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_st_reg <= ST_UNKNOWN))
        else $error("bad status code");

    a_offset_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg != ST_OK) |-> (out_off_reg == '0))
        else $error("offset given with a failure");

endmodule
`default_nettype wire

/* hw/rtl/ffa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* tb/first_fit_arena_allocator_top_test.sv */
`timescale 1ns / 1ps
module first_fit_arena_allocator_top_test;
    import ffa_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [OFF_W-1:0] offset;
        status_t          st;
    } grant_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                cmd;
    logic [SIZE_W-1:0]   alloc_size;
    logic [OFF_W-1:0]    free_offset;
    logic                out_valid;
    logic                out_ready;
    logic [OFF_W-1:0]    payload_offset;
    status_t             status;

    int unsigned         hdr_start [MAX_SEGMENTS];
    int unsigned         hdr_bytes [MAX_SEGMENTS];
    bit                  hdr_free [MAX_SEGMENTS];
    int unsigned         seg_total;

    grant_t              grant_queue [$];
    int unsigned         live_offsets [$];
    int                  error_count;
    int                  quiet_cycles = 0;
    bit                  timed_out;

    first_fit_arena_allocator_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .alloc_size(alloc_size),
        .free_offset(free_offset),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .payload_offset(payload_offset),
        .status(status)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic arena_clear();
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            hdr_start[k] = 0;
            hdr_bytes[k] = 0;
            hdr_free[k] = 1'b0;
        end
        hdr_bytes[0] = ARENA_BYTES - HEADER_BYTES;
        hdr_free[0] = 1'b1;
        seg_total = 1;
    endtask

    task automatic drop_seg(int unsigned idx);
        for (int unsigned k = idx; k + 1 < seg_total; k++)
        begin
            hdr_start[k] = hdr_start[k + 1];
            hdr_bytes[k] = hdr_bytes[k + 1];
            hdr_free[k] = hdr_free[k + 1];
        end
        seg_total--;
    endtask

    task automatic fold_next(int unsigned idx);
        hdr_bytes[idx] += HEADER_BYTES + hdr_bytes[idx + 1];
        drop_seg(idx + 1);
    endtask

    task automatic arena_alloc(int unsigned size, output grant_t g);
        int unsigned need;
        int          pick;
        pick = -1;
        g.offset = '0;
        if (size == 0)
        begin
            g.st = ST_ZERO;
            return;
        end
        if (seg_total >= MAX_SEGMENTS)
        begin
            g.st = ST_NOSPACE;
            return;
        end
        need = size + HEADER_BYTES;
        for (int unsigned i = 0; i < seg_total; i++)
        begin
            if (hdr_free[i] && hdr_bytes[i] >= need)
            begin
                pick = i;
                break;
            end
        end
        if (pick < 0)
        begin
            g.st = ST_NOSPACE;
            return;
        end
        for (int unsigned k = seg_total; k > pick + 1; k--)
        begin
            hdr_start[k] = hdr_start[k - 1];
            hdr_bytes[k] = hdr_bytes[k - 1];
            hdr_free[k] = hdr_free[k - 1];
        end
        hdr_start[pick + 1] = hdr_start[pick] + need;
        hdr_bytes[pick + 1] = hdr_bytes[pick] - need;
        hdr_free[pick + 1] = 1'b1;
        seg_total++;
        hdr_bytes[pick] = size;
        hdr_free[pick] = 1'b0;
        g.offset = OFF_W'(hdr_start[pick] + HEADER_BYTES);
        g.st = ST_OK;
    endtask

    task automatic arena_release(int unsigned off, output grant_t g);
        int unsigned i;
        g.offset = '0;
        if (off == 0)
        begin
            g.st = ST_NULL;
            return;
        end
        for (i = 0; i < seg_total; i++)
            if (hdr_start[i] + HEADER_BYTES == off)
                break;
        if (i >= seg_total)
        begin
            g.st = ST_UNKNOWN;
            return;
        end
        if (hdr_free[i])
        begin
            g.st = ST_DOUBLE;
            return;
        end
        hdr_free[i] = 1'b1;
        if (i + 1 < seg_total && hdr_free[i + 1])
            fold_next(i);
        if (i > 0 && hdr_free[i - 1])
            fold_next(i - 1);
        g.st = ST_OK;
    endtask

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_item(logic c, int unsigned size, int unsigned off);
        grant_t      g;
        int unsigned idle;
        idle = $urandom_range(0, 4);
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        cmd <= c;
        alloc_size <= SIZE_W'(size);
        free_offset <= OFF_W'(off);
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c == CMD_ALLOC)
        begin
            arena_alloc(SIZE_W'(size), g);
            if (g.st == ST_OK)
                live_offsets.push_back(g.offset);
        end
        else
        begin
            arena_release(OFF_W'(off), g);
        end
        grant_queue.push_back(g);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (grant_queue.size() != 0);
    endtask

    task automatic free_some(int unsigned n);
        int unsigned j;
        int unsigned off;
        repeat (n)
        begin
            if (live_offsets.size() == 0)
                return;
            j = $urandom_range(0, live_offsets.size() - 1);
            off = live_offsets[j];
            live_offsets.delete(j);
            send_item(CMD_FREE, $urandom_range(0, 8191), off);
        end
    endtask

    task automatic test_directed();
        send_item(CMD_ALLOC, 0, 0);
        send_item(CMD_FREE, 0, 0);
        send_item(CMD_ALLOC, 4096, 0);
        send_item(CMD_ALLOC, 8191, 4095);
        send_item(CMD_ALLOC, 4080, 0);
        send_item(CMD_FREE, 0, 8);
        send_item(CMD_FREE, 0, 8);
        send_item(CMD_ALLOC, 4088, 0);
        send_item(CMD_ALLOC, 16, 0);
        send_item(CMD_FREE, 0, 12);
        send_item(CMD_FREE, 0, 4095);
        send_item(CMD_ALLOC, 1, 0);
        send_item(CMD_ALLOC, 32, 0);
        send_item(CMD_FREE, 0, 8);
        send_item(CMD_FREE, 0, 32);
        send_item(CMD_FREE, 8191, 25);
        send_item(CMD_FREE, 0, 25);
        live_offsets.delete();
        drain();
    endtask

    task automatic test_table_full();
        for (int k = 0; k < 66; k++)
            send_item(CMD_ALLOC, $urandom_range(1, 40), 0);
        drain();
        free_some(70);
        drain();
    endtask

    task automatic test_random(int unsigned items);
        int unsigned r;
        for (int unsigned n = 0; n < items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(CMD_ALLOC, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                          : $urandom_range(1, 96), $urandom_range(0, 4095));
            else if (r < 85)
                free_some(1);
            else if (r < 90)
                send_item(CMD_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 4095));
            else if (r < 93)
                send_item(CMD_ALLOC, 0, $urandom_range(0, 4095));
            else
                send_item(CMD_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095));
            if (n == items / 2)
                drain();
        end
        free_some(live_offsets.size());
        send_item(CMD_ALLOC, 4088, 0);
        drain();
    endtask

    initial
    begin
        int unsigned idle;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            idle = $urandom_range(0, 4);
            if (idle != 0)
            begin
                out_ready <= 1'b0;
                repeat (idle) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (grant_queue.size() == 0)
            begin
                report("unexpected item", status, 0);
            end
            else
            begin
                automatic grant_t g = grant_queue.pop_front();
                if (payload_offset !== g.offset)
                    report("payload_offset", payload_offset, g.offset);
                if (status !== g.st)
                    report("status", status, g.st);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired at %0t", $realtime);
            $display("** first_fit_arena_allocator_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_ALLOC;
        alloc_size = '0;
        free_offset = '0;
        error_count = 0;
        arena_clear();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_table_full();
        test_random(1250);
        drain();
        repeat (300) @(negedge clk);
        if (error_count == 0 && grant_queue.size() == 0)
            $display("** first_fit_arena_allocator_top: PASSED **");
        else
            $display("** first_fit_arena_allocator_top: FAILED **");
        $finish;
    end

endmodule
